/* design/u8d_pkg.sv */
package u8d_pkg;

    localparam int unsigned CpW  = 21;
    localparam int unsigned CntW = 3;
    localparam int unsigned RemW = 2;

    localparam logic [7:0] LEAD2_MASK = 8'o037;
    localparam logic [7:0] LEAD3_MASK = 8'o017;
    localparam logic [7:0] LEAD4_MASK = 8'o007;
    localparam logic [7:0] CONT_MASK  = 8'o077;
    localparam logic [7:0] BYTE_MASK  = 8'o377;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_END     = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_flag;
    } t_in_item;

    typedef struct packed {
        logic [CpW-1:0]  code_point;
        logic [CntW-1:0] byte_count;
        t_status         status;
    } t_result;

    typedef struct packed {
        logic fire;
        logic load;
    } t_step;

endpackage

/* design/u8d_stream_if.sv */
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_flag;

    modport source (output valid, output data_byte, output end_flag, input ready);
    modport sink (input valid, input data_byte, input end_flag, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic [1:0]  status;

    modport source (output valid, output code_point, output byte_count, output status,
                    input ready);
    modport sink (input valid, input code_point, input byte_count, input status,
                  output ready);
endinterface

/* design/utf8_stream_decoder.sv */
// an item is held in the input register, and its result then in the result register
// throughput: one item per cycle unless a result waits on a stalled output; decode
// of a byte is a class test and a six-bit shift-or between the input register and the result register
// reset: synchronous active-low i_rst_n empties both registers and returns
// the decoder to the idle state with no open sequence
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_byte,
    u8d_out_if.source o_char
);

    logic     w_in_valid;
    t_in_item w_item;
    t_step    w_step;
    t_result  w_result;
    logic     w_out_free;

    u8d_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_step.fire),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    u8d_decode u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_in_valid),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .o_step     (w_step),
        .o_result   (w_result)
    );

    u8d_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_char   (o_char)
    );

endmodule

/* design/u8d_in_stage.sv */
module u8d_in_stage
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    u8d_in_if.sink   i_byte,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_ready;

    assign w_ready      = !r_valid || i_advance;
    assign i_byte.ready = w_ready;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_byte.valid) begin
            r_item.data_byte <= i_byte.data_byte & BYTE_MASK;
            r_item.end_flag  <= i_byte.end_flag;
        end
    end

endmodule

/* design/u8d_decode.sv */
module u8d_decode
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_out_free,
    output t_step    o_step,
    output t_result  o_result
);

    logic [RemW-1:0] r_rem;
    logic [CpW-1:0]  r_part;
    logic [CntW-1:0] r_taken;
    logic [RemW-1:0] n_rem;
    logic [CpW-1:0]  n_part;
    logic [CntW-1:0] n_taken;
    logic            w_has;
    logic            w_fire;
    logic            w_cont;
    logic [CpW-1:0]  w_ext;
    logic [7:0]      w_b;
    t_result         w_res;

    assign w_b    = i_item.data_byte;
    assign w_cont = (w_b[7:6] == 2'b10);
    assign w_ext  = {r_part[CpW-7:0], w_b[5:0] & CONT_MASK[5:0]};

    always_comb begin
        n_rem            = r_rem;
        n_part           = r_part;
        n_taken          = r_taken;
        w_has            = 1'b0;
        w_res.code_point = '0;
        w_res.byte_count = '0;
        w_res.status     = ST_OK;
        if (i_item.end_flag) begin
            w_has = 1'b1;
            if (r_rem != '0) begin
                w_res.byte_count = r_taken;
                w_res.status     = ST_TRUNC;
                n_rem            = '0;
                n_part           = '0;
                n_taken          = '0;
            end else begin
                w_res.status = ST_END;
            end
        end else if (r_rem != '0) begin
            if (w_cont) begin
                if (r_rem == RemW'(1)) begin
                    w_has            = 1'b1;
                    w_res.code_point = w_ext;
                    w_res.byte_count = r_taken + CntW'(1);
                    n_rem            = '0;
                    n_part           = '0;
                    n_taken          = '0;
                end else begin
                    n_part  = w_ext;
                    n_taken = r_taken + CntW'(1);
                    n_rem   = r_rem - RemW'(1);
                end
            end else begin
                w_has            = 1'b1;
                w_res.byte_count = r_taken + CntW'(1);
                w_res.status     = ST_INVALID;
                n_rem            = '0;
                n_part           = '0;
                n_taken          = '0;
            end
        end else if (!w_b[7]) begin
            w_has            = 1'b1;
            w_res.code_point = CpW'(w_b);
            w_res.byte_count = CntW'(1);
        end else if (w_cont || (w_b[7:3] == 5'b11111)) begin
            w_has            = 1'b1;
            w_res.byte_count = CntW'(1);
            w_res.status     = ST_INVALID;
        end else begin
            n_taken = CntW'(1);
            if (w_b[7:5] == 3'b110) begin
                n_part = CpW'(w_b & LEAD2_MASK);
                n_rem  = RemW'(1);
            end else if (w_b[7:4] == 4'b1110) begin
                n_part = CpW'(w_b & LEAD3_MASK);
                n_rem  = RemW'(2);
            end else begin
                n_part = CpW'(w_b & LEAD4_MASK);
                n_rem  = RemW'(3);
            end
        end
    end

    assign w_fire      = i_valid && (!w_has || i_out_free);
    assign o_step.fire = w_fire;
    assign o_step.load = w_fire && w_has;
    assign o_result    = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_part  <= '0;
            r_taken <= '0;
        end else if (w_fire) begin
            r_rem   <= n_rem;
            r_part  <= n_part;
            r_taken <= n_taken;
        end
    end

endmodule

/* design/u8d_out_stage.sv */
module u8d_out_stage
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_step    i_step,
    input  t_result  i_result,
    output logic     o_free,
    u8d_out_if.source o_char
);

    logic    r_valid;
    t_result r_res;
    logic    w_free;

    assign w_free            = !r_valid || o_char.ready;
    assign o_free            = w_free;
    assign o_char.valid      = r_valid;
    assign o_char.code_point = r_res.code_point;
    assign o_char.byte_count = r_res.byte_count;
    assign o_char.status     = r_res.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_step.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.load) begin
            r_res <= i_result;
        end
    end

endmodule

/* design/u8d_checker.sv */
module u8d_checker
    import u8d_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_code_point,
    input logic [2:0]  i_byte_count,
    input logic [1:0]  i_status
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point)
            && $stable(i_byte_count) && $stable(i_status))
        else $error("stalled result changed");

    a_err_no_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_code_point == '0))
        else $error("code point on a non-ok result");

    a_end_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_END) |-> (i_byte_count == '0))
        else $error("end of input with a byte count");

    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OK) |->
            (i_byte_count == 3'd1) || (i_byte_count == 3'd2)
            || (i_byte_count == 3'd3) || (i_byte_count == 3'd4))
        else $error("ok result with bad byte count");

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_char.valid),
    .i_out_ready  (o_char.ready),
    .i_code_point (o_char.code_point),
    .i_byte_count (o_char.byte_count),
    .i_status     (o_char.status)
);

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned PAUSE_AT     = 1000;
    localparam int unsigned HOLD_AT      = 600;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam logic [8:0]  END_MARK     = 9'h100;
    localparam logic [7:0]  CLASS_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_TAG     = 8'h80;

    class decode_scoreboard;
        logic [RemW-1:0] conts_left;
        logic [CpW-1:0]  cp_acc;
        logic [CntW-1:0] taken;
        t_result         chars_due[$];
        int unsigned     errors;

        function new();
            clear_seq();
            errors = 0;
        endfunction

        function void clear_seq();
            conts_left = '0;
            cp_acc     = '0;
            taken      = '0;
        endfunction

        function int unsigned outstanding();
            return chars_due.size();
        endfunction

        // predict the char, if any, that one accepted item produces
        function void take_item(logic [7:0] b, logic e);
            t_result r;
            r = '0;
            if (e) begin
                if (conts_left != 0) begin
                    r.byte_count = taken;
                    r.status     = ST_TRUNC;
                    clear_seq();
                end else begin
                    r.status = ST_END;
                end
                chars_due.push_back(r);
                return;
            end
            if (conts_left != 0) begin
                if ((b & CLASS_MASK) == CONT_TAG) begin
                    cp_acc     = (cp_acc << 6) | CpW'(b & CONT_MASK);
                    taken      = taken + 1'b1;
                    conts_left = conts_left - 1'b1;
                    if (conts_left == 0) begin
                        r.code_point = cp_acc;
                        r.byte_count = taken;
                        r.status     = ST_OK;
                        chars_due.push_back(r);
                        clear_seq();
                    end
                end else begin
                    r.byte_count = taken + 1'b1;
                    r.status     = ST_INVALID;
                    chars_due.push_back(r);
                    clear_seq();
                end
                return;
            end
            if (b < 8'h80) begin
                r.code_point = CpW'(b);
                r.byte_count = CntW'(1);
                r.status     = ST_OK;
                chars_due.push_back(r);
            end else if (b < 8'hC0 || b >= 8'hF8) begin
                r.byte_count = CntW'(1);
                r.status     = ST_INVALID;
                chars_due.push_back(r);
            end else begin
                if (b < 8'hE0) begin
                    cp_acc     = CpW'(b & LEAD2_MASK);
                    conts_left = RemW'(1);
                end else if (b < 8'hF0) begin
                    cp_acc     = CpW'(b & LEAD3_MASK);
                    conts_left = RemW'(2);
                end else begin
                    cp_acc     = CpW'(b & LEAD4_MASK);
                    conts_left = RemW'(3);
                end
                taken = CntW'(1);
            end
        endfunction

        function void check_char(logic [CpW-1:0] cp, logic [CntW-1:0] cnt, logic [1:0] st);
            t_result want;
            if (chars_due.size() == 0) begin
                $display("%0t unexpected char: code_point %0h byte_count %0d status %0d",
                         $time, cp, cnt, st);
                errors++;
                return;
            end
            want = chars_due.pop_front();
            if (cp !== want.code_point) begin
                $display("%0t code_point mismatch: expected %0h, got %0h",
                         $time, want.code_point, cp);
                errors++;
            end
            if (cnt !== want.byte_count) begin
                $display("%0t byte_count mismatch: expected %0d, got %0d",
                         $time, want.byte_count, cnt);
                errors++;
            end
            if (st !== want.status) begin
                $display("%0t status mismatch: expected %0d, got %0d",
                         $time, want.status, st);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    u8d_in_if  byte_if();
    u8d_out_if char_if();

    utf8_stream_decoder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_if),
        .o_char  (char_if)
    );

    decode_scoreboard board = new();

    int unsigned items_sent = 0;
    int unsigned tx_calm    = 0;
    int unsigned rx_calm    = 0;
    bit          rx_holding = 1'b0;
    bit          offering   = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] lead_byte(int unsigned len);
        logic [7:0] b;
        b = 8'($urandom);
        case (len)
            1: b[7] = 1'b0;
            2: b[7:5] = 3'b110;
            3: b[7:4] = 4'b1110;
            default: b[7:3] = 5'b11110;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic send_item(input logic [7:0] b, input logic e);
        int unsigned gap;
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.end_flag  <= e;
        offering = 1'b1;
        do @(posedge clk); while (byte_if.ready !== 1'b1);
        board.take_item(b, e);
        items_sent++;
        gap = rx_holding ? 0 : draw_gap(tx_calm);
        if (gap != 0) begin
            byte_if.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        if (offering) begin
            byte_if.valid <= 1'b0;
            offering = 1'b0;
        end
        while (board.outstanding() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_random_unit();
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = $urandom_range(1, 4);
            send_item(lead_byte(len), 1'b0);
            for (int i = 1; i < len; i++) send_item(cont_byte(), 1'b0);
        end else if (pick < 80) begin
            send_item(8'($urandom), 1'b0);
        end else if (pick < 95) begin
            // open a sequence, then break it or end the input inside it
            len = $urandom_range(2, 4);
            k = $urandom_range(0, len - 2);
            send_item(lead_byte(len), 1'b0);
            for (int i = 0; i < k; i++) send_item(cont_byte(), 1'b0);
            if (pick < 90) begin
                do b = 8'($urandom); while ((b & CLASS_MASK) == CONT_TAG);
                send_item(b, 1'b0);
            end else begin
                send_item(8'($urandom), 1'b1);
            end
        end else begin
            send_item(8'($urandom), 1'b1);
        end
    endtask

    initial begin : receiver
        int unsigned stall;
        int unsigned seen;
        bit          held;
        stall = 0;
        seen  = 0;
        held  = 1'b0;
        char_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (char_if.valid && char_if.ready) begin
                board.check_char(char_if.code_point, char_if.byte_count, char_if.status);
                seen++;
            end
            if (!rst_n) begin
                char_if.ready <= 1'b0;
            end else if (!held && seen >= HOLD_AT) begin
                held = 1'b1;
                rx_holding = 1'b1;
                char_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_holding = 1'b0;
                char_if.ready <= 1'b1;
            end else if (stall != 0) begin
                stall--;
                char_if.ready <= 1'b0;
            end else begin
                char_if.ready <= 1'b1;
                stall = draw_gap(rx_calm);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [8:0] directed [24];
        bit         paused;
        paused = 1'b0;
        // ascii ends, lone continuation, bad lead, 2/3/4-byte extremes,
        // break inside a sequence, end while idle, end inside a sequence
        directed = '{9'h000, 9'h07F, 9'h080, 9'h0FF,
                     9'h0C0, 9'h080,
                     9'h0EF, 9'h0BF, 9'h0BF,
                     9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
                     9'h0DF, 9'h041,
                     9'h0F0, 9'h080, 9'h0F8,
                     END_MARK,
                     9'h0E0, 9'h080, END_MARK,
                     9'h0F4, END_MARK};
        rst_n             <= 1'b0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= '0;
        byte_if.end_flag  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_item(directed[i][7:0], directed[i][8]);
        wait_drained();

        while (items_sent < RANDOM_ITEMS) begin
            send_random_unit();
            if (!paused && items_sent >= PAUSE_AT) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        wait_drained();

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
design/u8d_pkg.sv
design/u8d_stream_if.sv
design/u8d_in_stage.sv
design/u8d_decode.sv
design/u8d_out_stage.sv
design/utf8_stream_decoder.sv
design/u8d_checker.sv
verif/testbench.sv
